@@ rtl/utf8d_pkg.sv @@
// Shared types and constants for the UTF-8 stream decoder.
package utf8d_pkg;

  localparam logic [20:0] REPL_CP = 21'h00FFFD;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  byte_count;
    logic        is_replacement;
    logic        last_of_run;
  } out_word_t;

  // One decoded byte's worth of results: repl_count replacements, then an optional tail.
  typedef struct packed {
    logic [1:0]  repl_count;
    logic        tail_valid;
    logic [20:0] tail_cp;
    logic [2:0]  tail_count;
    logic        tail_rep;
  } run_t;

endpackage

@@ rtl/utf8d_front.sv @@
// Front end: byte classification and sequence state, builds at most one run per byte.
module utf8d_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  utf8d_pkg::in_word_t src,
  output logic               run_push,
  output utf8d_pkg::run_t    run
);
  import utf8d_pkg::*;

  logic [1:0]  bytes_expected;
  logic [1:0]  bytes_held;
  logic [20:0] partial_code;
  logic [1:0]  bytes_expected_next;
  logic [1:0]  bytes_held_next;
  logic [20:0] partial_code_next;

  logic [7:0]  b;
  logic        eot;
  logic        as_lead;
  logic [20:0] shifted;
  logic [2:0]  lead_len;
  logic [20:0] lead_init;

  assign b       = src.data_byte;
  assign eot     = src.end_of_text;
  assign shifted = {partial_code[14:0], b[5:0]};

  always_comb begin
    lead_len  = 3'd0;
    lead_init = '0;
    if (b[7:5] == 3'b110) begin
      lead_len  = 3'd2;
      lead_init = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      lead_len  = 3'd3;
      lead_init = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      lead_len  = 3'd4;
      lead_init = {18'd0, b[2:0]};
    end
  end

  always_comb begin
    run                 = '0;
    as_lead             = 1'b1;
    bytes_expected_next = bytes_expected;
    bytes_held_next     = bytes_held;
    partial_code_next   = partial_code;

    if (bytes_expected != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        as_lead = 1'b0;
        if (bytes_expected == 2'd1) begin
          run.tail_valid      = 1'b1;
          run.tail_cp         = shifted;
          run.tail_count      = {1'b0, bytes_held} + 3'd1;
          run.tail_rep        = 1'b0;
          bytes_expected_next = 2'd0;
          bytes_held_next     = 2'd0;
          partial_code_next   = '0;
        end else if (eot) begin
          run.repl_count      = bytes_held + 2'd1;
          bytes_expected_next = 2'd0;
          bytes_held_next     = 2'd0;
          partial_code_next   = '0;
        end else begin
          bytes_expected_next = bytes_expected - 2'd1;
          bytes_held_next     = bytes_held + 2'd1;
          partial_code_next   = shifted;
        end
      end else begin
        // Broken sequence: replace held bytes, then retry this byte as a lead.
        run.repl_count      = bytes_held;
        bytes_expected_next = 2'd0;
        bytes_held_next     = 2'd0;
        partial_code_next   = '0;
      end
    end

    if (as_lead) begin
      if (!b[7]) begin
        run.tail_valid = 1'b1;
        run.tail_cp    = {13'd0, b};
        run.tail_count = 3'd1;
        run.tail_rep   = 1'b0;
      end else if (lead_len == 3'd0 || eot) begin
        run.tail_valid = 1'b1;
        run.tail_cp    = REPL_CP;
        run.tail_count = 3'd1;
        run.tail_rep   = 1'b1;
      end else begin
        bytes_expected_next = lead_len[1:0] - 2'd1;
        bytes_held_next     = 2'd1;
        partial_code_next   = lead_init;
      end
    end

    if (eot) begin
      bytes_expected_next = 2'd0;
      bytes_held_next     = 2'd0;
      partial_code_next   = '0;
    end
  end

  assign run_push = accept && (run.repl_count != 2'd0 || run.tail_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_expected <= 2'd0;
      bytes_held     <= 2'd0;
      partial_code   <= '0;
    end else if (accept) begin
      bytes_expected <= bytes_expected_next;
      bytes_held     <= bytes_held_next;
      partial_code   <= partial_code_next;
    end
  end

endmodule

@@ rtl/utf8d_fifo.sv @@
// Short run queue between the front and back ends.
module utf8d_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  utf8d_pkg::run_t wr_data,
  input  logic            rd_en,
  output utf8d_pkg::run_t rd_data,
  output logic            full,
  output logic            empty
);
  import utf8d_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  run_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/utf8d_back.sv @@
// Back end: expands each queued run into result words, one per cycle while the result register is empty or popped.
module utf8d_back (
  input  logic                 clk,
  input  logic                 rst,
  input  utf8d_pkg::run_t      run,
  input  logic                 run_empty,
  output logic                 run_pop,
  input  logic                 pop,
  output logic                 empty,
  output utf8d_pkg::out_word_t result
);
  import utf8d_pkg::*;

  logic       out_valid;
  logic [1:0] idx;
  logic       load;
  logic       in_repl;
  logic       run_done;
  out_word_t  word_next;

  assign empty   = !out_valid;
  assign load    = !run_empty && (!out_valid || pop);
  assign in_repl = (idx < run.repl_count);

  always_comb begin
    if (in_repl) begin
      word_next.code_point     = REPL_CP;
      word_next.byte_count     = 3'd1;
      word_next.is_replacement = 1'b1;
      run_done                 = (idx == run.repl_count - 2'd1) && !run.tail_valid;
    end else begin
      word_next.code_point     = run.tail_cp;
      word_next.byte_count     = run.tail_count;
      word_next.is_replacement = run.tail_rep;
      run_done                 = 1'b1;
    end
    word_next.last_of_run = run_done;
  end

  assign run_pop = load && run_done;

  always_ff @(posedge clk) begin
    if (load) begin
      result <= word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        // advance within the run, or restart on the next one
        idx       <= run_done ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/utf8_stream_decoder.sv @@
// UTF-8 stream decoder: one byte in per cycle while full is low, decoded code point words out.
// A byte's run passes through the run queue and then the result register to the result ports.
// The front end takes one byte per cycle while the run queue has room; the back end emits
// a run's words one at a time, so the run queue (QUEUE_DEPTH runs) absorbs multi-word bytes.
// Reset: clears the pending sequence, the run queue and the output valid flag; no fill pass.
module utf8_stream_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  utf8d_pkg::in_word_t  src,
  output logic                 empty,
  input  logic                 pop,
  output utf8d_pkg::out_word_t result
);
  import utf8d_pkg::*;

  logic q_full;
  logic q_empty;
  logic q_pop;
  logic q_push;
  logic accept;
  run_t front_run;
  run_t head_run;

  assign full   = q_full;
  assign accept = push && !q_full;

  utf8d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .src      (src),
    .run_push (q_push),
    .run      (front_run)
  );

  utf8d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (front_run),
    .rd_en   (q_pop),
    .rd_data (head_run),
    .full    (q_full),
    .empty   (q_empty)
  );

  utf8d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .run       (head_run),
    .run_empty (q_empty),
    .run_pop   (q_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule

@@ tb/utf8_stream_decoder_test.sv @@
// Self-checking testbench for the UTF-8 stream decoder: directed and random byte texts.
module utf8_stream_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import utf8d_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  logic      full;
  logic      empty;
  in_word_t  src = '0;
  out_word_t result;

  utf8_stream_decoder uut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .src    (src),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  in_word_t  pending_bytes[$];
  out_word_t expected_words[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int bytes_queued = 0;
  int bytes_accepted = 0;
  int words_checked = 0;
  int replacements_seen = 0;
  int longest_run = 0;
  int error_count = 0;

  // Decoder state mirror
  logic [1:0]  seq_need = 2'd0;
  logic [1:0]  seq_held = 2'd0;
  logic [20:0] seq_value = 21'd0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void expect_word(logic [20:0] cp, logic [2:0] cnt, logic rep);
    out_word_t w;
    w.code_point     = cp;
    w.byte_count     = cnt;
    w.is_replacement = rep;
    w.last_of_run    = 1'b0;
    expected_words = {expected_words, w};
  endfunction

  function automatic void expect_replacements(int count);
    for (int i = 0; i < count; i++) expect_word(REPL_CP, 3'd1, 1'b1);
  endfunction

  function automatic void clear_sequence();
    seq_need  = 2'd0;
    seq_held  = 2'd0;
    seq_value = 21'd0;
  endfunction

  // Work out every word that one accepted byte releases.
  function automatic void decode_byte(in_word_t w);
    logic [7:0]  b;
    logic        eot;
    logic        as_lead;
    int          seq_len;
    logic [20:0] lead_bits;
    int          first_idx;
    int          n;
    out_word_t   tail;
    b = w.data_byte;
    eot = w.end_of_text;
    as_lead = 1'b1;
    seq_len = 0;
    lead_bits = 21'd0;
    first_idx = expected_words.size();
    if (seq_need != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        as_lead = 1'b0;
        seq_value = {seq_value[14:0], b[5:0]};
        if (seq_need == 2'd1) begin
          expect_word(seq_value, 3'(seq_held) + 3'd1, 1'b0);
          clear_sequence();
        end else if (eot) begin
          expect_replacements(int'(seq_held) + 1);
          clear_sequence();
        end else begin
          seq_need = seq_need - 2'd1;
          seq_held = seq_held + 2'd1;
        end
      end else begin
        // broken sequence: every held byte becomes a replacement
        expect_replacements(int'(seq_held));
        clear_sequence();
      end
    end
    if (as_lead) begin
      if (b[7] == 1'b0) begin
        expect_word({13'd0, b}, 3'd1, 1'b0);
      end else begin
        if (b[7:5] == 3'b110) begin
          seq_len = 2;
          lead_bits = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
          seq_len = 3;
          lead_bits = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
          seq_len = 4;
          lead_bits = {18'd0, b[2:0]};
        end
        if (seq_len == 0 || eot) begin
          expect_word(REPL_CP, 3'd1, 1'b1);
        end else begin
          seq_need  = 2'(seq_len - 1);
          seq_held  = 2'd1;
          seq_value = lead_bits;
        end
      end
    end
    if (eot) clear_sequence();
    n = expected_words.size() - first_idx;
    if (n > 0) begin
      tail = expected_words.pop_back();
      tail.last_of_run = 1'b1;
      expected_words = {expected_words, tail};
    end
    if (n > longest_run) longest_run = n;
  endfunction

  function automatic void check_word(out_word_t got);
    out_word_t want;
    if (expected_words.size() == 0) begin
      $error("unexpected word: code_point %h byte_count %0d", got.code_point, got.byte_count);
      error_count++;
      return;
    end
    want = expected_words.pop_front();
    words_checked++;
    if (got.is_replacement) replacements_seen++;
    if (got.code_point !== want.code_point) begin
      $error("code_point: expected %h, got %h", want.code_point, got.code_point);
      error_count++;
    end
    if (got.byte_count !== want.byte_count) begin
      $error("byte_count: expected %0d, got %0d", want.byte_count, got.byte_count);
      error_count++;
    end
    if (got.is_replacement !== want.is_replacement) begin
      $error("is_replacement: expected %b, got %b", want.is_replacement, got.is_replacement);
      error_count++;
    end
    if (got.last_of_run !== want.last_of_run) begin
      $error("last_of_run: expected %b, got %b", want.last_of_run, got.last_of_run);
      error_count++;
    end
  endfunction

  // Driver: hold the word until taken, then maybe advance to the next one.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        decode_byte(src);
        bytes_accepted++;
      end
      if (!push || !full) begin
        if (pending_bytes.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          src  <= pending_bytes.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_word(result);
      pop <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  function automatic void queue_byte(logic [7:0] b, logic eot);
    in_word_t w;
    w.data_byte   = b;
    w.end_of_text = eot;
    pending_bytes = {pending_bytes, w};
    bytes_queued++;
  endfunction

  function automatic logic [7:0] lead_for(int len);
    if (len == 2) return {3'b110, 5'($urandom)};
    if (len == 3) return {4'b1110, 4'($urandom)};
    return {5'b11110, 3'($urandom)};
  endfunction

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom)};
  endfunction

  // One random text: mostly well-formed characters, some broken or cut short.
  function automatic void add_text();
    logic [7:0] text[$];
    int         kind;
    int         len;
    logic [7:0] b;
    if ($urandom_range(9, 0) == 0) begin
      repeat ($urandom_range(6, 1)) queue_byte(8'($urandom), $urandom_range(4, 0) == 0);
      return;
    end
    repeat ($urandom_range(8, 1)) begin
      kind = $urandom_range(99, 0);
      if (kind < 30) begin
        text = {text, 8'($urandom_range(127, 0))};
      end else if (kind < 77) begin
        len = (kind < 50) ? 2 : (kind < 65) ? 3 : 4;
        text = {text, lead_for(len)};
        repeat (len - 1) text = {text, cont_byte()};
      end else if (kind < 83) begin
        if ($urandom_range(1, 0)) text = {text, 8'($urandom_range(191, 128))};
        else text = {text, 8'($urandom_range(255, 248))};
      end else begin
        len = $urandom_range(4, 2);
        text = {text, lead_for(len)};
        repeat ($urandom_range(len - 2, 0)) text = {text, cont_byte()};
        if (kind >= 93) begin
          // follow with a byte that cannot continue the sequence
          b = 8'($urandom);
          if (b[7:6] == 2'b10) b[6] = 1'b1;
          text = {text, b};
        end
      end
    end
    for (int i = 0; i < text.size(); i++) queue_byte(text[i], i == text.size() - 1);
  endfunction

  task automatic wait_drained();
    while (bytes_accepted != bytes_queued || expected_words.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // ASCII extremes, one character of each length, the largest 4-byte value
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h7F, 1'b1);
    queue_byte(8'hC2, 1'b0);
    queue_byte(8'hA9, 1'b0);
    queue_byte(8'hE2, 1'b0);
    queue_byte(8'h82, 1'b0);
    queue_byte(8'hAC, 1'b0);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'h9F, 1'b0);
    queue_byte(8'h98, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hF7, 1'b0);
    queue_byte(8'hBF, 1'b0);
    queue_byte(8'hBF, 1'b0);
    queue_byte(8'hBF, 1'b0);
    // invalid leads: stray continuation and F8..FF
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hFF, 1'b0);
    // bad continuation, then the byte decoded as ASCII
    queue_byte(8'hE2, 1'b0);
    queue_byte(8'h41, 1'b0);
    // three held bytes broken by a lead that also ends the text: four words
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'h9F, 1'b0);
    queue_byte(8'h98, 1'b0);
    queue_byte(8'hE1, 1'b1);
    // text ends on a good continuation, and on a bare lead
    queue_byte(8'hE2, 1'b0);
    queue_byte(8'h82, 1'b1);
    queue_byte(8'hC3, 1'b1);

    // hold the sender until every expected word is out
    wait_drained();

    send_idle_pct = 30;
    recv_idle_pct = 86;
    while (bytes_queued < 190) add_text();
    while (bytes_accepted != bytes_queued) @(posedge clk);

    send_idle_pct = 86;
    recv_idle_pct = 30;
    while (bytes_queued < 340) add_text();
    while (bytes_accepted != bytes_queued) @(posedge clk);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (bytes_queued < 470) add_text();
    wait_drained();
    repeat (10) @(posedge clk);

    $display("Decoded %0d bytes into %0d words (%0d replacements), up to %0d words per byte.",
             bytes_accepted, words_checked, replacements_seen, longest_run);
    $display("Covered valid 1- to 4-byte forms, invalid leads, broken and truncated sequences.");
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("** utf8_stream_decoder: PASSED **");
    end else begin
      $display("** utf8_stream_decoder: FAILED **");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Timeout with %0d words outstanding", expected_words.size());
    $display("** utf8_stream_decoder: FAILED **");
    $finish;
  end

endmodule
